### rtl/bc_pkg.sv
`default_nettype none

package bc_pkg;

   localparam int COEF_W     = 16;
   localparam int RAW_W      = 24;
   localparam int TEMP_W     = 19;
   localparam int PRES_W     = 24;
   localparam int DT_W       = RAW_W + 1;
   localparam int TPROD_W    = DT_W + COEF_W + 1;
   localparam int A_W        = 18;
   localparam int B_W        = A_W + 1;
   localparam int SQ_W       = 35;
   localparam int OFF_W      = 41;
   localparam int OFF_CORR_W = OFF_W - 1;
   localparam int SENS_W     = 39;
   localparam int SENS_CORR_W = SENS_W - 1;
   localparam int SLO_W      = 20;
   localparam int SHI_W      = SENS_W - SLO_W;
   localparam int LO_W       = RAW_W + SLO_W;
   localparam int HI_W       = RAW_W + 1 + SHI_W;
   localparam int MUL_W      = 64;
   localparam int PQ_W       = MUL_W - 21;
   localparam int DIFF_W     = PQ_W + 1;
   localparam int PFULL_W    = DIFF_W - 15;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE  = 19'sd2000;
   localparam logic signed [B_W-1:0]    COLD_SHIFT = 19'sd3500;

   localparam int OFF_SQ_GAIN    = 61;
   localparam int SENS_SQ_GAIN   = 29;
   localparam int OFF_COLD_GAIN  = 17;
   localparam int SENS_COLD_GAIN = 9;
   localparam int CORR_SHIFT     = 4;

   localparam logic signed [PRES_W-1:0] PRES_MAX = 24'sh7FFFFF;
   localparam logic signed [PRES_W-1:0] PRES_MIN = 24'sh800000;

   typedef enum logic [2:0] {
      REG_SENS        = 3'd0,
      REG_OFFSET      = 3'd1,
      REG_SENS_TEMP   = 3'd2,
      REG_OFFSET_TEMP = 3'd3,
      REG_REF_TEMP    = 3'd4,
      REG_TEMP_SLOPE  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] sens;
      logic [COEF_W-1:0] offset;
      logic [COEF_W-1:0] sens_temp;
      logic [COEF_W-1:0] offset_temp;
      logic [COEF_W-1:0] ref_temp;
      logic [COEF_W-1:0] temp_slope;
   } coef_type;

   typedef struct packed {
      logic                       valid;
      logic [RAW_W-1:0]           pressure_raw;
      logic signed [TEMP_W-1:0]   temperature;
      logic signed [OFF_W-1:0]    offset;
      logic signed [SENS_W-1:0]   sens;
   } terms_type;

   typedef struct packed {
      logic                       valid;
      logic signed [TEMP_W-1:0]   temperature;
      logic signed [PRES_W-1:0]   pressure;
      logic                       clipped;
   } result_type;

endpackage

`default_nettype wire

### rtl/bc_csr.sv
`default_nettype none

module bc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [bc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [bc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bc_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                  pready,
   output bc_pkg::coef_type                      coef
);
   import bc_pkg::*;

   coef_type      coef_ff, coef_in;
   reg_index_type index;
   logic          wr_en;
   logic [COEF_W-1:0] wr_val;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign wr_val = pwdata[COEF_W-1:0];
   assign coef   = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         case (index)
            REG_SENS:        coef_in.sens        = wr_val;
            REG_OFFSET:      coef_in.offset      = wr_val;
            REG_SENS_TEMP:   coef_in.sens_temp   = wr_val;
            REG_OFFSET_TEMP: coef_in.offset_temp = wr_val;
            REG_REF_TEMP:    coef_in.ref_temp    = wr_val;
            REG_TEMP_SLOPE:  coef_in.temp_slope  = wr_val;
            default:         coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SENS:        prdata = CSR_DATA_W'(coef_ff.sens);
         REG_OFFSET:      prdata = CSR_DATA_W'(coef_ff.offset);
         REG_SENS_TEMP:   prdata = CSR_DATA_W'(coef_ff.sens_temp);
         REG_OFFSET_TEMP: prdata = CSR_DATA_W'(coef_ff.offset_temp);
         REG_REF_TEMP:    prdata = CSR_DATA_W'(coef_ff.ref_temp);
         REG_TEMP_SLOPE:  prdata = CSR_DATA_W'(coef_ff.temp_slope);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

`default_nettype wire

### rtl/bc_terms.sv
`default_nettype none

module bc_terms (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [bc_pkg::RAW_W-1:0]      pressure_raw,
   input  wire logic [bc_pkg::RAW_W-1:0]      temperature_raw,
   input  bc_pkg::coef_type                   coef,
   output bc_pkg::terms_type                  terms
);
   import bc_pkg::*;

   // stage 1: dT
   logic                      v1_ff;
   logic [RAW_W-1:0]          d1_1_ff;
   logic signed [DT_W-1:0]    dt_1_ff, dt_1_in;

   // stage 2: dT products
   logic                      v2_ff;
   logic [RAW_W-1:0]          d1_2_ff;
   logic signed [TPROD_W-1:0] p6_2_ff, p4_2_ff, p3_2_ff;
   logic signed [TPROD_W-1:0] p6_2_in, p4_2_in, p3_2_in;

   // stage 3: first-order terms
   logic                      v3_ff;
   logic [RAW_W-1:0]          d1_3_ff;
   logic signed [A_W-1:0]     a_3_ff, a_3_in;
   logic signed [B_W-1:0]     b_3_ff, b_3_in;
   logic signed [TEMP_W-1:0]  temp_3_ff, temp_3_in;
   logic signed [OFF_W-1:0]   off_3_ff, off_3_in;
   logic signed [SENS_W-1:0]  sens_3_ff, sens_3_in;
   logic                      cold_3_ff, cold_3_in;
   logic                      vcold_3_ff, vcold_3_in;

   // stage 4: squares
   logic                      v4_ff;
   logic [RAW_W-1:0]          d1_4_ff;
   logic signed [TEMP_W-1:0]  temp_4_ff;
   logic signed [OFF_W-1:0]   off_4_ff;
   logic signed [SENS_W-1:0]  sens_4_ff;
   logic [SQ_W-1:0]           sq_4_ff, sq_4_in;
   logic [SQ_W-1:0]           sq2_4_ff, sq2_4_in;
   logic signed [2*A_W-1:0]   asq;
   logic signed [2*B_W-1:0]   bsq;

   // stage 5: corrections
   logic                      v5_ff;
   logic [RAW_W-1:0]          d1_5_ff;
   logic signed [TEMP_W-1:0]  temp_5_ff;
   logic signed [OFF_W-1:0]   off_5_ff;
   logic signed [SENS_W-1:0]  sens_5_ff;
   logic [OFF_CORR_W-1:0]     off_corr_5_ff, off_corr_5_in;
   logic [SENS_CORR_W-1:0]    sens_corr_5_ff, sens_corr_5_in;
   logic [OFF_CORR_W:0]       sq61;
   logic [SENS_CORR_W+1:0]    sq29;

   // stage 6: corrected terms
   terms_type                 t6_ff, t6_in;

   assign dt_1_in = $signed({1'b0, temperature_raw}) - $signed({1'b0, coef.ref_temp, 8'b0});

   assign p6_2_in = TPROD_W'(dt_1_ff) * TPROD_W'($signed({1'b0, coef.temp_slope}));
   assign p4_2_in = TPROD_W'(dt_1_ff) * TPROD_W'($signed({1'b0, coef.offset_temp}));
   assign p3_2_in = TPROD_W'(dt_1_ff) * TPROD_W'($signed({1'b0, coef.sens_temp}));

   always_comb begin
      a_3_in     = $signed(p6_2_ff[A_W+22:23]);
      temp_3_in  = TEMP_W'(a_3_in) + TEMP_BASE;
      b_3_in     = B_W'(a_3_in) + COLD_SHIFT;
      cold_3_in  = a_3_in[A_W-1];
      vcold_3_in = b_3_in[B_W-1];
      off_3_in   = $signed(OFF_W'({coef.offset, 17'b0}))
                 + OFF_W'($signed(p4_2_ff[TPROD_W-1:6]));
      sens_3_in  = $signed(SENS_W'({coef.sens, 16'b0}))
                 + SENS_W'($signed(p3_2_ff[TPROD_W-2:7]));
   end

   always_comb begin
      asq      = a_3_ff * a_3_ff;
      bsq      = b_3_ff * b_3_ff;
      sq_4_in  = cold_3_ff ? asq[SQ_W-1:0] : '0;
      sq2_4_in = vcold_3_ff ? bsq[SQ_W-1:0] : '0;
   end

   always_comb begin
      sq61 = (OFF_CORR_W+1)'(sq_4_ff) * (OFF_CORR_W+1)'(OFF_SQ_GAIN);
      sq29 = (SENS_CORR_W+2)'(sq_4_ff) * (SENS_CORR_W+2)'(SENS_SQ_GAIN);
      off_corr_5_in  = OFF_CORR_W'(sq61 >> CORR_SHIFT)
                     + OFF_CORR_W'(sq2_4_ff) * OFF_CORR_W'(OFF_COLD_GAIN);
      sens_corr_5_in = SENS_CORR_W'(sq29 >> CORR_SHIFT)
                     + SENS_CORR_W'(sq2_4_ff) * SENS_CORR_W'(SENS_COLD_GAIN);
   end

   always_comb begin
      t6_in.valid        = v5_ff;
      t6_in.pressure_raw = d1_5_ff;
      t6_in.temperature  = temp_5_ff;
      t6_in.offset       = off_5_ff - $signed({1'b0, off_corr_5_ff});
      t6_in.sens         = sens_5_ff - $signed({1'b0, sens_corr_5_ff});
   end

   assign terms = t6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         v5_ff       <= 1'b0;
         t6_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         t6_ff.valid <= t6_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_1_ff <= pressure_raw;
         dt_1_ff <= dt_1_in;

         d1_2_ff <= d1_1_ff;
         p6_2_ff <= p6_2_in;
         p4_2_ff <= p4_2_in;
         p3_2_ff <= p3_2_in;

         d1_3_ff    <= d1_2_ff;
         a_3_ff     <= a_3_in;
         b_3_ff     <= b_3_in;
         temp_3_ff  <= temp_3_in;
         off_3_ff   <= off_3_in;
         sens_3_ff  <= sens_3_in;
         cold_3_ff  <= cold_3_in;
         vcold_3_ff <= vcold_3_in;

         d1_4_ff   <= d1_3_ff;
         temp_4_ff <= temp_3_ff;
         off_4_ff  <= off_3_ff;
         sens_4_ff <= sens_3_ff;
         sq_4_ff   <= sq_4_in;
         sq2_4_ff  <= sq2_4_in;

         d1_5_ff        <= d1_4_ff;
         temp_5_ff      <= temp_4_ff;
         off_5_ff       <= off_4_ff;
         sens_5_ff      <= sens_4_ff;
         off_corr_5_ff  <= off_corr_5_in;
         sens_corr_5_ff <= sens_corr_5_in;

         t6_ff.pressure_raw <= t6_in.pressure_raw;
         t6_ff.temperature  <= t6_in.temperature;
         t6_ff.offset       <= t6_in.offset;
         t6_ff.sens         <= t6_in.sens;
      end
   end

endmodule

`default_nettype wire

### rtl/bc_press.sv
`default_nettype none

module bc_press (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  bc_pkg::terms_type  terms,
   output bc_pkg::result_type result
);
   import bc_pkg::*;

   // stage 7: partial products of D1 * SENS
   logic                      v7_ff;
   logic signed [TEMP_W-1:0]  temp_7_ff;
   logic signed [OFF_W-1:0]   off_7_ff;
   logic [LO_W-1:0]           lo_7_ff, lo_7_in;
   logic signed [HI_W-1:0]    hi_7_ff, hi_7_in;

   // stage 8: full product, floor shift by 21
   logic                      v8_ff;
   logic signed [TEMP_W-1:0]  temp_8_ff;
   logic signed [OFF_W-1:0]   off_8_ff;
   logic signed [MUL_W-1:0]   prod;
   logic signed [PQ_W-1:0]    pq_8_ff, pq_8_in;

   // stage 9: subtract offset, shift, saturate
   result_type                r9_ff, r9_in;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PFULL_W-1:0] pfull;
   logic                      fits;

   assign lo_7_in = LO_W'(terms.pressure_raw) * LO_W'(terms.sens[SLO_W-1:0]);
   assign hi_7_in = HI_W'($signed({1'b0, terms.pressure_raw}))
                  * HI_W'($signed(terms.sens[SENS_W-1:SLO_W]));

   assign prod    = (MUL_W'(hi_7_ff) <<< SLO_W) + $signed(MUL_W'(lo_7_ff));
   assign pq_8_in = $signed(prod[MUL_W-1:MUL_W-PQ_W]);

   always_comb begin
      diff  = DIFF_W'(pq_8_ff) - DIFF_W'(off_8_ff);
      pfull = $signed(diff[DIFF_W-1:DIFF_W-PFULL_W]);
      fits  = (pfull[PFULL_W-1:PRES_W-1] == '0) || (pfull[PFULL_W-1:PRES_W-1] == '1);
      r9_in.valid       = v8_ff;
      r9_in.temperature = temp_8_ff;
      r9_in.clipped     = !fits;
      if (fits) begin
         r9_in.pressure = pfull[PRES_W-1:0];
      end else if (pfull[PFULL_W-1]) begin
         r9_in.pressure = PRES_MIN;
      end else begin
         r9_in.pressure = PRES_MAX;
      end
   end

   assign result = r9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff       <= 1'b0;
         v8_ff       <= 1'b0;
         r9_ff.valid <= 1'b0;
      end else if (en) begin
         v7_ff       <= terms.valid;
         v8_ff       <= v7_ff;
         r9_ff.valid <= r9_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         temp_7_ff <= terms.temperature;
         off_7_ff  <= terms.offset;
         lo_7_ff   <= lo_7_in;
         hi_7_ff   <= hi_7_in;

         temp_8_ff <= temp_7_ff;
         off_8_ff  <= off_7_ff;
         pq_8_ff   <= pq_8_in;

         r9_ff.temperature <= r9_in.temperature;
         r9_ff.pressure    <= r9_in.pressure;
         r9_ff.clipped     <= r9_in.clipped;
      end
   end

endmodule

`default_nettype wire

### rtl/bc_skid.sv
`default_nettype none

module bc_skid (
   input  wire logic           clock,
   input  wire logic           reset,
   input  bc_pkg::result_type  in_result,
   output logic                en,
   output bc_pkg::result_type  out_result,
   input  wire logic           out_ready
);
   import bc_pkg::*;

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       take;

   assign en         = !skid_ff.valid;
   assign take       = out_ff.valid & out_ready;
   assign out_result = out_ff;

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (!out_ff.valid || take) begin
         if (skid_ff.valid) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end else begin
            out_in = in_result;
         end
      end else if (in_result.valid && en) begin
         skid_in = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         out_ff.valid  <= out_in.valid;
         skid_ff.valid <= skid_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      out_ff.temperature  <= out_in.temperature;
      out_ff.pressure     <= out_in.pressure;
      out_ff.clipped      <= out_in.clipped;
      skid_ff.temperature <= skid_in.temperature;
      skid_ff.pressure    <= skid_in.pressure;
      skid_ff.clipped     <= skid_in.clipped;
   end

endmodule

`default_nettype wire

### rtl/barometer_compensation.sv
// Second-order compensation for a barometric pressure sensor. Each transaction on the req_
// stream carries one raw pressure and one raw temperature conversion; the rsp_ stream returns
// the temperature in hundredths of a degree C and the pressure in pascals, saturated to 24
// signed bits with a clip flag in tuser. The six calibration coefficients sit in 16-bit
// registers at byte addresses 0x00 to 0x14 of the csr_ port and must be written while no
// transaction is in flight. The datapath is a nine-stage pipeline behind a two-entry output
// buffer: it takes one transaction per clock while the output buffer has room, and the whole
// pipeline stalls while rsp_tready holds results back and the buffer fills.
`default_nettype none

module barometer_compensation (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [23:0] pressure_raw, [47:24] temperature_raw
   input  wire logic [47:0]                    req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [18:0] temperature_centi, [42:19] pressure_pa, [47:43] zero
   output logic [47:0]                         rsp_tdata,
   // [0] pressure_clipped
   output logic                                rsp_tuser,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [bc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [bc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                csr_pready
);
   import bc_pkg::*;

   coef_type   coef;
   terms_type  terms;
   result_type result;
   result_type out_result;
   logic       en;

   bc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .coef    (coef)
   );

   bc_terms u_terms (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_tvalid),
      .pressure_raw    (req_tdata[RAW_W-1:0]),
      .temperature_raw (req_tdata[2*RAW_W-1:RAW_W]),
      .coef            (coef),
      .terms           (terms)
   );

   bc_press u_press (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .terms  (terms),
      .result (result)
   );

   bc_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .in_result  (result),
      .en         (en),
      .out_result (out_result),
      .out_ready  (rsp_tready)
   );

   assign req_tready = en;
   assign rsp_tvalid = out_result.valid;
   assign rsp_tdata  = {5'b0, out_result.pressure, out_result.temperature};
   assign rsp_tuser  = out_result.clipped;

endmodule

`default_nettype wire

### bench/barometer_compensation_checker.sv
`timescale 1ns / 100ps

module barometer_compensation_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   // [23:0] pressure_raw, [47:24] temperature_raw
   input  wire logic [47:0]                    req_tdata,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [18:0] temperature_centi, [42:19] pressure_pa, [47:43] zero
   input  wire logic [47:0]                    rsp_tdata,
   // [0] pressure_clipped
   input  wire logic                           rsp_tuser,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [bc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [bc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  wire logic [bc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  wire logic                           csr_pready,
   output int                                  fail_count,
   output int                                  in_flight,
   output int                                  checked,
   output int                                  cold_seen,
   output int                                  frigid_seen,
   output int                                  clipped_seen
);
   import bc_pkg::*;

   localparam longint TEMP_REF    = 2000;
   localparam longint COLD_REF    = -1500;
   localparam longint OFF_SQ      = 61;
   localparam longint SENS_SQ     = 29;
   localparam longint OFF_COLD    = 17;
   localparam longint SENS_COLD   = 9;
   localparam longint PRES_TOP    = 8388607;
   localparam longint PRES_BOTTOM = -8388608;
   localparam int     MAX_REPORTS = 40;
   localparam int     DATA_W      = 48;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [PRES_W-1:0] pres;
      logic                     clip;
   } reading_type;

   logic [COEF_W-1:0] coef_bank [6];
   reading_type       expected_readings [$];

   function automatic reading_type compensate(input logic [RAW_W-1:0] p_raw,
                                              input logic [RAW_W-1:0] t_raw);
      reading_type r;
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, dev, chill, pres;
      d1 = p_raw;
      d2 = t_raw;
      c1 = coef_bank[REG_SENS];
      c2 = coef_bank[REG_OFFSET];
      c3 = coef_bank[REG_SENS_TEMP];
      c4 = coef_bank[REG_OFFSET_TEMP];
      c5 = coef_bank[REG_REF_TEMP];
      c6 = coef_bank[REG_TEMP_SLOPE];
      dt   = d2 - c5 * 256;
      temp = TEMP_REF + ((dt * c6) >>> 23);
      off  = c2 * 131072 + ((dt * c4) >>> 6);
      sens = c1 * 65536 + ((dt * c3) >>> 7);
      if (temp < TEMP_REF) begin
         dev  = (temp - TEMP_REF) * (temp - TEMP_REF);
         off  -= (OFF_SQ * dev) >>> 4;
         sens -= (SENS_SQ * dev) >>> 4;
         if (temp < COLD_REF) begin
            chill = (temp - COLD_REF) * (temp - COLD_REF);
            off  -= OFF_COLD * chill;
            sens -= SENS_COLD * chill;
         end
      end
      pres = (((d1 * sens) >>> 21) - off) >>> 15;
      r.clip = 1'b0;
      if (pres < PRES_BOTTOM) begin
         pres   = PRES_BOTTOM;
         r.clip = 1'b1;
      end else if (pres > PRES_TOP) begin
         pres   = PRES_TOP;
         r.clip = 1'b1;
      end
      r.temp = TEMP_W'(temp);
      r.pres = PRES_W'(pres);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("MISMATCH at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      reading_type want;
      logic [2:0]  idx;
      if (reset) begin
         for (int i = 0; i < 6; i++)
            coef_bank[i] = '0;
         expected_readings.delete();
      end else begin
         idx = csr_paddr[CSR_ADDR_W-1:2];
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (idx <= REG_TEMP_SLOPE)
                  coef_bank[idx] = csr_pwdata[COEF_W-1:0];
            end else if (idx <= REG_TEMP_SLOPE &&
                         csr_prdata !== CSR_DATA_W'(coef_bank[idx])) begin
               report_mismatch($sformatf("register %0d reads %h, expected %h",
                                         idx, csr_prdata, coef_bank[idx]));
            end
         end

         if (req_tvalid && req_tready) begin
            want = compensate(req_tdata[RAW_W-1:0], req_tdata[2*RAW_W-1:RAW_W]);
            if (want.temp < TEMP_REF) cold_seen++;
            if (want.temp < COLD_REF) frigid_seen++;
            if (want.clip) clipped_seen++;
            expected_readings.push_back(want);
         end

         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("unexpected result transaction %h/%b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata[TEMP_W-1:0] !== want.temp)
                  report_mismatch($sformatf("temperature %0d, expected %0d",
                                            $signed(rsp_tdata[TEMP_W-1:0]), want.temp));
               if (rsp_tdata[TEMP_W+PRES_W-1:TEMP_W] !== want.pres)
                  report_mismatch($sformatf("pressure %0d, expected %0d",
                                            $signed(rsp_tdata[TEMP_W+PRES_W-1:TEMP_W]),
                                            want.pres));
               if (rsp_tdata[DATA_W-1:TEMP_W+PRES_W] !== '0)
                  report_mismatch($sformatf("padding bits %b not zero",
                                            rsp_tdata[DATA_W-1:TEMP_W+PRES_W]));
               if (rsp_tuser !== want.clip)
                  report_mismatch($sformatf("clip flag %b, expected %b",
                                            rsp_tuser, want.clip));
            end
         end
      end
      in_flight <= expected_readings.size();
   end

endmodule

### bench/tb_barometer_compensation.sv
`timescale 1ns / 100ps

module tb_barometer_compensation;
   import bc_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 30;
   localparam int RANDOM_SETS     = 8;
   localparam int SAMPLES_PER_SET = 175;
   localparam logic [RAW_W-1:0] RAW_MAX = '1;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [47:0]            req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [47:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int fail_count, in_flight, checked, cold_seen, frigid_seen, clipped_seen;
   int idle_cycles;
   int req_odds, rsp_odds;
   int sets_loaded;
   bit calm;
   logic [COEF_W-1:0] cal [6];
   logic [RAW_W-1:0]  ref_code;

   barometer_compensation uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   barometer_compensation_checker bc_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .in_flight    (in_flight),
      .checked      (checked),
      .cold_seen    (cold_seen),
      .frigid_seen  (frigid_seen),
      .clipped_seen (clipped_seen)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && rsp_odds != 0 && $urandom_range(1, 16) <= rsp_odds) begin
            stall = $urandom_range(1, 12);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_access(input logic write, input int idx,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits carry junk; an unmapped slot is hit now and then
   task automatic load_cal();
      for (int i = 0; i <= REG_TEMP_SLOPE; i++)
         csr_access(1'b1, i, {16'($urandom), cal[i]});
      if ($urandom_range(0, 1))
         csr_access(1'b1, REG_TEMP_SLOPE + 1 + $urandom_range(0, 1), $urandom);
      for (int i = 0; i <= REG_TEMP_SLOPE; i++)
         csr_access(1'b0, i, '0);
      sets_loaded++;
   endtask

   task automatic set_typical();
      cal[REG_SENS]        = 16'd40127;
      cal[REG_OFFSET]      = 16'd36924;
      cal[REG_SENS_TEMP]   = 16'd23317;
      cal[REG_OFFSET_TEMP] = 16'd23282;
      cal[REG_REF_TEMP]    = 16'd33464;
      cal[REG_TEMP_SLOPE]  = 16'd28312;
   endtask

   task automatic pick_cal(input int flavor);
      if (flavor == 0)
         set_typical();
      for (int i = 0; i <= REG_TEMP_SLOPE; i++) begin
         case (flavor)
            0: cal[i] = cal[i] ^ COEF_W'($urandom_range(0, 4095));
            1: cal[i] = COEF_W'($urandom);
            default: begin
               case ($urandom_range(0, 2))
                  0: cal[i] = '0;
                  1: cal[i] = '1;
                  default: cal[i] = COEF_W'($urandom);
               endcase
            end
         endcase
      end
   endtask

   task automatic send_sample(input logic [RAW_W-1:0] p_raw, input logic [RAW_W-1:0] t_raw);
      int gap;
      if (!calm && req_odds != 0 && $urandom_range(1, 16) <= req_odds) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t_raw, p_raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] edge_value();
      logic [RAW_W-1:0] one_hot;
      one_hot = RAW_W'(1) << $urandom_range(0, RAW_W - 1);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return RAW_MAX;
         2: return one_hot;
         3: return ~one_hot;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   task automatic random_sample();
      logic [RAW_W-1:0] p_raw, t_raw;
      int     pick, swing;
      longint level;
      pick  = $urandom_range(0, 9);
      p_raw = RAW_W'($urandom);
      t_raw = RAW_W'($urandom);
      if (pick < 4) begin
         // near the reference reading, where the sensor normally lives
         swing = $urandom_range(0, 2**22) - 2**21;
         level = longint'(cal[REG_REF_TEMP]) * 256 + swing;
         if (level < 0)
            level = 0;
         else if (level > longint'(RAW_MAX))
            level = longint'(RAW_MAX);
         t_raw = RAW_W'(level);
      end else if (pick >= 8) begin
         p_raw = edge_value();
         t_raw = edge_value();
      end
      send_sample(p_raw, t_raw);
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      calm        = 1'b0;
      req_odds    = 4;
      rsp_odds    = 4;
      sets_loaded = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients
      send_sample('0, '0);
      send_sample(RAW_MAX, RAW_MAX);
      settle();

      set_typical();
      load_cal();
      ref_code = {cal[REG_REF_TEMP], 8'd0};
      send_sample('0, ref_code);                          // exactly 20.00 C
      send_sample(RAW_MAX, ref_code - 24'd1);             // 19.99 C
      send_sample(24'd6465444, 24'd8077636);
      send_sample(24'd6465444, ref_code - 24'd1037020);   // -15.00 C, no cold term
      send_sample(24'd6465444, ref_code - 24'd1037021);   // -15.01 C
      send_sample(RAW_MAX, '0);
      send_sample('0, RAW_MAX);
      settle();

      for (int i = 0; i <= REG_TEMP_SLOPE; i++)
         cal[i] = '0;
      load_cal();
      send_sample(RAW_MAX, '0);
      send_sample('0, RAW_MAX);
      settle();

      // all coefficients at full scale: both saturation directions
      for (int i = 0; i <= REG_TEMP_SLOPE; i++)
         cal[i] = '1;
      load_cal();
      send_sample('0, '0);
      send_sample(RAW_MAX, '0);
      send_sample(RAW_MAX, RAW_MAX);
      send_sample('0, RAW_MAX);
      settle();

      for (int s = 0; s < RANDOM_SETS; s++) begin
         pick_cal(s % 3);
         req_odds = $urandom_range(0, 6);
         rsp_odds = $urandom_range(0, 6);
         calm     = (s == RANDOM_SETS - 1);
         load_cal();
         repeat (SAMPLES_PER_SET) random_sample();
         settle();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d compensated readings across %0d coefficient sets",
               checked, sets_loaded);
      $display("%0d below 20 C, %0d below -15 C, %0d with saturated pressure",
               cold_seen, frigid_seen, clipped_seen);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
